// ----- rtl/multi_queue_linked_buffer_top_macros.svh -----
// Assertion macros shared by the RTL of the linked queue buffer.
// Every macro expects signals named clk and rst_n in the calling scope.
`ifndef MULTI_QUEUE_LINKED_BUFFER_TOP_MACROS_SVH
`define MULTI_QUEUE_LINKED_BUFFER_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define MQLB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mqlb: invariant violated");

// When the trigger holds, the condition holds at the same edge.
`define MQLB_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("mqlb: implication violated");

// When the trigger holds, the condition holds at the following edge.
`define MQLB_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("mqlb: sequence violated");

`endif

// ----- rtl/mqlb_pkg.sv -----
package mqlb_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_NUM_W = 4;
    localparam int STATUS_W    = 2;
    localparam int IN_USER_W   = 1 + QUEUE_NUM_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

endpackage

// ----- rtl/mqlb_ram.sv -----
module mqlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/multi_queue_linked_buffer_top.sv -----
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tuser: req_type, queue_num; tdata: data_in
// m        out  m_tvalid/m_tready  tuser: status; tdata: data_out
//
// A request accepted in IDLE reads the link and data memories; EXEC then
// updates the lists and loads the result. The single read port of each memory
// and the free-list head, which every request consumes, keep the block to one
// request at a time. A stalled result holds the update step until the output
// register frees up. After reset the block is ready at once: slots never
// allocated are tracked by a fill count instead of a clearing pass.
`include "multi_queue_linked_buffer_top_macros.svh"

module multi_queue_linked_buffer_top #(
    parameter int NUM_SLOTS  = 64,
    parameter int NUM_QUEUES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mqlb_pkg::DATA_W-1:0]     s_tdata,   // [31:0] data_in
    input  logic [mqlb_pkg::IN_USER_W-1:0]  s_tuser,   // [0] req_type, [4:1] queue_num
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mqlb_pkg::DATA_W-1:0]     m_tdata,   // [31:0] data_out
    output logic [mqlb_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);

    localparam int AW  = $clog2(NUM_SLOTS);
    localparam int PW  = $clog2(NUM_SLOTS + 1);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QNW = mqlb_pkg::QUEUE_NUM_W;
    localparam int QXW = (QIW > QNW) ? QIW : QNW;
    localparam logic [PW-1:0] NIL = PW'(NUM_SLOTS);

    mqlb_pkg::state_t  state_reg, state_next;
    logic              req_reg;
    logic              qok_reg;
    logic [QIW-1:0]    qidx_reg;
    logic [mqlb_pkg::DATA_W-1:0] word_reg;
    logic [PW-1:0]     head_reg [NUM_QUEUES];
    logic [PW-1:0]     head_next [NUM_QUEUES];
    logic [PW-1:0]     tail_reg [NUM_QUEUES];
    logic [PW-1:0]     tail_next [NUM_QUEUES];
    logic [PW-1:0]     free_head_reg, free_head_next;
    logic [PW-1:0]     fill_cnt_reg, fill_cnt_next;
    logic              out_valid_reg, out_valid_next;
    mqlb_pkg::status_t status_reg, status_next;
    logic [mqlb_pkg::DATA_W-1:0] dout_reg, dout_next;

    logic              in_req;
    logic [QNW-1:0]    in_qnum;
    logic [QXW-1:0]    in_qx;
    logic [QIW-1:0]    in_qidx;
    logic              in_qok;
    logic              accept;
    logic [AW-1:0]     rd_addr;

    logic [PW-1:0]     link_rd;
    logic [mqlb_pkg::DATA_W-1:0] data_rd;
    logic              link_we;
    logic [AW-1:0]     link_waddr;
    logic              data_we;

    logic [PW-1:0]     cur_head;
    logic [PW-1:0]     cur_tail;
    logic              go;
    logic              enq_ok;
    logic              deq_ok;
    logic [PW-1:0]     deq_next_ptr;

    assign in_req  = s_tuser[0];
    assign in_qnum = s_tuser[QNW:1];
    assign in_qx   = QXW'(in_qnum) - QXW'(1);
    assign in_qidx = in_qx[QIW-1:0];
    assign in_qok  = (in_qnum != '0) && (32'(in_qnum) <= NUM_QUEUES);

    assign s_tready = (state_reg == mqlb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // A dequeue reads the queue head's link and word; an enqueue reads the
    // link of the free-list head.
    assign rd_addr = (in_req == mqlb_pkg::REQ_DEQ) ? head_reg[in_qidx][AW-1:0]
                                                   : free_head_reg[AW-1:0];

    assign cur_head = head_reg[qidx_reg];
    assign cur_tail = tail_reg[qidx_reg];
    assign go       = (state_reg == mqlb_pkg::ST_EXEC) && (!out_valid_reg || m_tready);
    assign enq_ok   = (req_reg == mqlb_pkg::REQ_ENQ) && qok_reg && (free_head_reg != NIL);
    assign deq_ok   = (req_reg == mqlb_pkg::REQ_DEQ) && qok_reg && (cur_head != NIL);

    // The tail's stored link is never kept up to date, so a one-entry queue is
    // recognized by head equal to tail.
    assign deq_next_ptr = (cur_head == cur_tail) ? NIL : link_rd;

    // Enqueue links the new slot after the tail; dequeue pushes the freed
    // slot onto the free list. Both write the current free-list head.
    assign link_we    = go && ((enq_ok && (cur_head != NIL)) || deq_ok);
    assign link_waddr = (req_reg == mqlb_pkg::REQ_ENQ) ? cur_tail[AW-1:0] : cur_head[AW-1:0];
    assign data_we    = go && enq_ok;

    mqlb_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (free_head_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    mqlb_ram #(
        .WIDTH (mqlb_pkg::DATA_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (free_head_reg[AW-1:0]),
        .wr_data (word_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (data_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fill_cnt_next  = fill_cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        dout_next      = dout_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mqlb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mqlb_pkg::ST_EXEC;
                end
            end
            mqlb_pkg::ST_EXEC:
            begin
                if (go)
                begin
                    state_next     = mqlb_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    dout_next      = '0;
                    if (req_reg == mqlb_pkg::REQ_ENQ)
                    begin
                        status_next = mqlb_pkg::STATUS_FULL;
                        if (enq_ok)
                        begin
                            status_next = mqlb_pkg::STATUS_OK;
                            // Slots at or above the fill count were never
                            // linked; the next free slot follows in order.
                            if (free_head_reg >= fill_cnt_reg)
                            begin
                                free_head_next = free_head_reg + PW'(1);
                                fill_cnt_next  = fill_cnt_reg + PW'(1);
                            end
                            else
                            begin
                                free_head_next = link_rd;
                            end
                            if (cur_head == NIL)
                            begin
                                head_next[qidx_reg] = free_head_reg;
                            end
                            tail_next[qidx_reg] = free_head_reg;
                        end
                    end
                    else
                    begin
                        status_next = mqlb_pkg::STATUS_EMPTY;
                        if (deq_ok)
                        begin
                            status_next         = mqlb_pkg::STATUS_OK;
                            dout_next           = data_rd;
                            head_next[qidx_reg] = deq_next_ptr;
                            if (deq_next_ptr == NIL)
                            begin
                                tail_next[qidx_reg] = NIL;
                            end
                            free_head_next = cur_head;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mqlb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mqlb_pkg::ST_IDLE;
            free_head_reg <= '0;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= in_req;
            qok_reg  <= in_qok;
            qidx_reg <= in_qidx;
            word_reg <= s_tdata;
        end
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dout_reg;
    assign m_tuser  = status_reg;

    `MQLB_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
    `MQLB_ASSERT_NEXT(a_hold_while_blocked, (state_reg == mqlb_pkg::ST_EXEC) && out_valid_reg && !m_tready, state_reg == mqlb_pkg::ST_EXEC)
    `MQLB_ASSERT_SAME(a_free_list_drained, free_head_reg == NIL, fill_cnt_reg == PW'(NUM_SLOTS))
    `MQLB_ASSERT_SAME(a_zero_on_fail, m_tvalid && (m_tuser != mqlb_pkg::STATUS_OK), m_tdata == '0)
    `MQLB_ASSERT_ALWAYS(a_fill_bound, fill_cnt_reg <= PW'(NUM_SLOTS))

endmodule
